// File: rtl/flrc_pkg.sv
// ----------------------------------------------------------------------------
// flrc_pkg
// Shared types, constants and the CRC-8 step for the framed link receiver.
// ----------------------------------------------------------------------------
package flrc_pkg;

    localparam int unsigned MAX_PAYLOAD  = 8;
    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned MAX_FRAME    = HEADER_BYTES + MAX_PAYLOAD + 1;
    localparam int unsigned IDX_W        = 3;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [7:0] START_BYTE_RST = 8'hAA;
    localparam logic [7:0] CRC_POLY       = 8'h07;

    localparam logic RESULT_TEXT  = 1'b0;
    localparam logic RESULT_FRAME = 1'b1;

    typedef enum logic [2:0] {
        OP_TEXT,
        OP_SOF,
        OP_ID_LO,
        OP_ID_HI,
        OP_LEN,
        OP_PAYLOAD,
        OP_CRC
    } t_op_kind;

    typedef struct packed {
        t_op_kind         kind;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } t_op_item;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: rtl/framed_link_receiver_crc8_top.sv
// ----------------------------------------------------------------------------
// framed_link_receiver_crc8_top
// Byte-stream receiver: passes text bytes, checks and unpacks CRC-8 frames.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_ready with i_rx_byte, one byte per transfer.
// Output channel: o_valid/i_ready with kind, text byte, id, length, payload.
// Frame: start byte, id low, id high, length (0..8), payload, CRC-8 (poly
// 0x07, init 0) over all bytes before the CRC byte.
// Idle bytes other than the start byte leave as text results. A frame with
// a length above 8 or a bad CRC produces nothing.
// Throughput: one byte per cycle sustained while the output is not held. The
// frame tracker classifies each byte in the cycle it arrives and feeds a
// two-entry queue; the result builder drains one op per cycle from it and
// puts each result in the output register. A result passes through the queue
// and then the output register; each op queued ahead of it delays it further.
// Reset (synchronous, active low) returns to idle, empties the queue, drops
// any pending result and sets the start byte to 0xAA. i_cfg_wr_en writes the
// start byte; write it only while the block is idle.
// When i_ready is low the result holds; ops that produce no result keep
// draining, and o_ready drops once the queue fills.
// ----------------------------------------------------------------------------
module framed_link_receiver_crc8_top import flrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_text_byte,
    output logic [15:0] o_message_id,
    output logic [3:0]  o_payload_length,
    output logic [63:0] o_payload_data
);

    logic     push;
    t_op_item push_item;
    logic     q_ready;
    logic     q_valid;
    t_op_item q_item;
    logic     pop;

    flrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_push        (push),
        .o_item        (push_item),
        .i_q_ready     (q_ready)
    );

    flrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    flrc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_item           (q_item),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_kind    (o_result_kind),
        .o_text_byte      (o_text_byte),
        .o_message_id     (o_message_id),
        .o_payload_length (o_payload_length),
        .o_payload_data   (o_payload_data)
    );

endmodule

// File: rtl/flrc_front.sv
// ----------------------------------------------------------------------------
// flrc_front
// Frame tracker: accepts bytes, follows frame position, emits classified ops.
// ----------------------------------------------------------------------------
module flrc_front import flrc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_op_item   o_item,
    input  logic       i_q_ready
);

    logic [7:0] r_start_byte;
    logic       r_in_frame, n_in_frame;
    logic [3:0] r_pos, n_pos;
    logic [3:0] r_exp, n_exp;
    logic       accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        n_exp       = r_exp;
        o_push      = 1'b0;
        o_item.kind = OP_TEXT;
        o_item.data = i_rx_byte;
        o_item.idx  = '0;
        if (accept) begin
            priority if (!r_in_frame) begin
                o_push = 1'b1;
                if (i_rx_byte == r_start_byte) begin
                    o_item.kind = OP_SOF;
                    n_in_frame  = 1'b1;
                    n_pos       = 4'd1;
                    n_exp       = '0;
                end
            end else if (r_pos >= 4'(MAX_FRAME)) begin
                n_in_frame = 1'b0;
                n_pos      = '0;
                n_exp      = '0;
            end else if (r_pos == 4'd1) begin
                o_push      = 1'b1;
                o_item.kind = OP_ID_LO;
                n_pos       = 4'd2;
            end else if (r_pos == 4'd2) begin
                o_push      = 1'b1;
                o_item.kind = OP_ID_HI;
                n_pos       = 4'd3;
            end else if (r_pos == 4'd3) begin
                if (i_rx_byte > 8'(MAX_PAYLOAD)) begin
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                    n_exp      = '0;
                end else begin
                    o_push      = 1'b1;
                    o_item.kind = OP_LEN;
                    n_exp       = 4'(HEADER_BYTES + 1) + i_rx_byte[3:0];
                    n_pos       = 4'(HEADER_BYTES);
                end
            end else if (r_exp != '0 && r_pos == r_exp - 4'd1) begin
                o_push      = 1'b1;
                o_item.kind = OP_CRC;
                n_in_frame  = 1'b0;
                n_pos       = '0;
                n_exp       = '0;
            end else begin
                o_push      = 1'b1;
                o_item.kind = OP_PAYLOAD;
                o_item.idx  = IDX_W'(r_pos - 4'(HEADER_BYTES));
                n_pos       = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_in_frame   <= 1'b0;
            r_pos        <= '0;
            r_exp        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_byte <= i_cfg_wr_data;
            end
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_exp      <= n_exp;
        end
    end

`ifndef SYNTHESIS
    a_crc_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.kind == OP_CRC) |=> !r_in_frame)
        else $error("frame still open after CRC byte");
    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_pos == '0 && r_exp == '0))
        else $error("frame position not cleared while idle");
`endif

endmodule

// File: rtl/flrc_queue.sv
// ----------------------------------------------------------------------------
// flrc_queue
// Two-entry op queue between the frame tracker and the result builder.
// ----------------------------------------------------------------------------
module flrc_queue import flrc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_op_item i_item,
    output logic     o_ready,
    output logic     o_valid,
    output t_op_item o_item,
    input  logic     i_pop
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op_item           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_ready = r_count < CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(QUEUE_DEPTH) && !do_pop) |=> r_count == CNT_W'(QUEUE_DEPTH))
        else $error("queue count moved while full");
`endif

endmodule

// File: rtl/flrc_back.sv
// ----------------------------------------------------------------------------
// flrc_back
// Result builder: header/payload capture, running CRC-8, output register.
// ----------------------------------------------------------------------------
module flrc_back import flrc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_op_item    i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_text_byte,
    output logic [15:0] o_message_id,
    output logic [3:0]  o_payload_length,
    output logic [63:0] o_payload_data
);

    logic [15:0] r_id;
    logic [3:0]  r_len;
    logic [63:0] r_payload;
    logic [7:0]  r_crc;
    logic        r_out_valid;
    logic        r_kind;
    logic [7:0]  r_text;
    logic [15:0] r_mid;
    logic [3:0]  r_plen;
    logic [63:0] r_pdata;

    logic [7:0]  crc_next;
    logic        crc_good;
    logic        makes_result;
    logic        out_free;

    assign crc_next     = crc8_step((i_item.kind == OP_SOF) ? 8'h00 : r_crc, i_item.data);
    assign crc_good     = i_item.data == r_crc;
    assign makes_result = (i_item.kind == OP_TEXT) || (i_item.kind == OP_CRC && crc_good);
    assign out_free     = !r_out_valid || i_ready;
    assign o_pop        = i_q_valid && (out_free || !makes_result);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_item.kind)
                OP_SOF: begin
                    r_id      <= '0;
                    r_len     <= '0;
                    r_payload <= '0;
                    r_crc     <= crc_next;
                end
                OP_ID_LO: begin
                    r_id[7:0] <= i_item.data;
                    r_crc     <= crc_next;
                end
                OP_ID_HI: begin
                    r_id[15:8] <= i_item.data;
                    r_crc      <= crc_next;
                end
                OP_LEN: begin
                    r_len <= i_item.data[3:0];
                    r_crc <= crc_next;
                end
                OP_PAYLOAD: begin
                    r_payload <= r_payload | (64'(i_item.data) << {i_item.idx, 3'b000});
                    r_crc     <= crc_next;
                end
                OP_TEXT: begin
                    r_kind  <= RESULT_TEXT;
                    r_text  <= i_item.data;
                    r_mid   <= '0;
                    r_plen  <= '0;
                    r_pdata <= '0;
                end
                OP_CRC: begin
                    if (crc_good) begin
                        r_kind  <= RESULT_FRAME;
                        r_text  <= '0;
                        r_mid   <= r_id;
                        r_plen  <= r_len;
                        r_pdata <= r_payload;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && makes_result) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_text_byte      = r_text;
    assign o_message_id     = r_mid;
    assign o_payload_length = r_plen;
    assign o_payload_data   = r_pdata;

`ifndef SYNTHESIS
    a_text_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == RESULT_TEXT) |->
            (o_message_id == '0 && o_payload_length == '0 && o_payload_data == '0))
        else $error("text result carries frame fields");
    a_frame_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == RESULT_FRAME) |->
            (o_text_byte == '0 && o_payload_length <= 4'(MAX_PAYLOAD)))
        else $error("frame result out of range");
`endif

endmodule

// File: verif/framed_link_receiver_crc8_tb.sv
// ----------------------------------------------------------------------------
// testbench
// Checks framed_link_receiver_crc8_top against a cycle-free predictor of the
// byte-stream receiver. A directed table covers text bytes, the largest and
// smallest frames, start bytes inside a frame, an oversized length and a bad
// CRC. Random traffic follows under several start-byte settings. Each phase
// mixes well-formed frames with random content, broken frames and noise,
// with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
    import flrc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int PHASE_ITEMS   = 460;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text;
        logic [15:0] id;
        logic [3:0]  len;
        logic [63:0] data;
    } rx_result_t;

    typedef enum logic [2:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_TEXT,
        ROW_CRC_GOOD,
        ROW_CRC_BAD
    } row_kind_e;

    typedef struct packed {
        row_kind_e  how;
        logic [7:0] value;
    } stim_row_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_rx_byte     = 8'h00;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_result_kind;
    logic [7:0]  o_text_byte;
    logic [15:0] o_message_id;
    logic [3:0]  o_payload_length;
    logic [63:0] o_payload_data;

    // predictor state
    logic [7:0]  cfg_start  = START_BYTE_RST;
    logic        fr_active  = 1'b0;
    logic [3:0]  fr_pos     = '0;
    logic [3:0]  fr_total   = '0;
    logic [15:0] fr_id      = '0;
    logic [3:0]  fr_len     = '0;
    logic [63:0] fr_payload = '0;
    logic [7:0]  fr_crc     = '0;

    rx_result_t pending_results[$];
    int         fail_count  = 0;
    int         items_sent  = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;
    bit         hold_request = 1'b0;

    stim_row_t directed_rows [29] = '{
        '{ROW_TEXT, 8'h00}, '{ROW_TEXT, 8'hFF},
        // empty frame, all-zero id and length
        '{ROW_QUIET, 8'hAA}, '{ROW_QUIET, 8'h00}, '{ROW_QUIET, 8'h00},
        '{ROW_QUIET, 8'h00}, '{ROW_CRC_GOOD, 8'h00},
        // full frame, start byte repeated as payload
        '{ROW_QUIET, 8'hAA}, '{ROW_QUIET, 8'hFF}, '{ROW_QUIET, 8'hFF},
        '{ROW_QUIET, 8'h08}, '{ROW_QUIET, 8'hAA}, '{ROW_QUIET, 8'h00},
        '{ROW_QUIET, 8'hFF}, '{ROW_QUIET, 8'h80}, '{ROW_QUIET, 8'h01},
        '{ROW_QUIET, 8'h5A}, '{ROW_QUIET, 8'hA5}, '{ROW_QUIET, 8'h7E},
        '{ROW_CRC_GOOD, 8'h00},
        // start byte as id, then oversized length
        '{ROW_QUIET, 8'hAA}, '{ROW_QUIET, 8'hAA}, '{ROW_QUIET, 8'hAA},
        '{ROW_QUIET, 8'h09},
        // bad CRC
        '{ROW_QUIET, 8'hAA}, '{ROW_QUIET, 8'h34}, '{ROW_QUIET, 8'h12},
        '{ROW_QUIET, 8'h00}, '{ROW_CRC_BAD, 8'h00}
    };

    framed_link_receiver_crc8_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_kind    (o_result_kind),
        .o_text_byte      (o_text_byte),
        .o_message_id     (o_message_id),
        .o_payload_length (o_payload_length),
        .o_payload_data   (o_payload_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        return r;
    endfunction

    function automatic void tracker_idle();
        fr_active = 1'b0;
        fr_pos    = '0;
        fr_total  = '0;
    endfunction

    // advances the tracker by one byte; returns 1 when a result is produced
    function automatic bit frame_predict(input logic [7:0] b, output rx_result_t r);
        int unsigned slot;
        r = '0;
        if (!fr_active) begin
            if (b == cfg_start) begin
                fr_active  = 1'b1;
                fr_pos     = 4'd1;
                fr_total   = '0;
                fr_id      = '0;
                fr_len     = '0;
                fr_payload = '0;
                fr_crc     = crc8_next(8'h00, b);
                return 1'b0;
            end
            r.kind = RESULT_TEXT;
            r.text = b;
            return 1'b1;
        end
        if (fr_pos >= MAX_FRAME) begin
            tracker_idle();
            return 1'b0;
        end
        if (fr_pos == 4'd1) begin
            fr_id[7:0] = b;
        end else if (fr_pos == 4'd2) begin
            fr_id[15:8] = b;
        end else if (fr_pos == 4'd3) begin
            if (b > MAX_PAYLOAD) begin
                tracker_idle();
                return 1'b0;
            end
            fr_len   = b[3:0];
            fr_total = 4'(HEADER_BYTES + b + 1);
        end else if (fr_total != 0 && fr_pos == fr_total - 4'd1) begin
            tracker_idle();
            if (b != fr_crc) begin
                return 1'b0;
            end
            r.kind = RESULT_FRAME;
            r.id   = fr_id;
            r.len  = fr_len;
            r.data = fr_payload;
            return 1'b1;
        end else begin
            slot = (fr_pos - HEADER_BYTES) & 7;
            fr_payload |= 64'(b) << (8 * slot);
        end
        fr_crc = crc8_next(fr_crc, b);
        fr_pos = fr_pos + 4'd1;
        return 1'b0;
    endfunction

    // offers one byte in the current step, waits for the transfer, then predicts
    task automatic send_rx_byte(input logic [7:0] b, input row_kind_e how);
        rx_result_t r;
        bit         got;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        items_sent++;
        got = frame_predict(b, r);
        case (how)
            ROW_QUIET: ;
            ROW_TEXT: begin
                r      = '0;
                r.kind = RESULT_TEXT;
                r.text = b;
                pending_results.push_back(r);
            end
            default: begin
                if (got) begin
                    pending_results.push_back(r);
                end
            end
        endcase
    endtask

    task automatic finish_frame_and_drain();
        while (fr_active) send_rx_byte(8'($urandom), ROW_PREDICT);
        i_valid    <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_byte(input logic [7:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_start = v;
    endtask

    task automatic random_traffic(input int target);
        int         pick;
        logic [7:0] len;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                finish_frame_and_drain();
            end else if (pick < 17) begin
                repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom), ROW_PREDICT);
            end else begin
                while (fr_active) send_rx_byte(8'($urandom), ROW_PREDICT);
                send_rx_byte(cfg_start, ROW_PREDICT);
                send_rx_byte(8'($urandom), ROW_PREDICT);
                send_rx_byte(8'($urandom), ROW_PREDICT);
                if ($urandom_range(0, 19) == 0) begin
                    send_rx_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)), ROW_PREDICT);
                end else begin
                    len = 8'($urandom_range(0, MAX_PAYLOAD));
                    send_rx_byte(len, ROW_PREDICT);
                    repeat (len) send_rx_byte(8'($urandom), ROW_PREDICT);
                    if ($urandom_range(0, 9) == 0) begin
                        send_rx_byte(fr_crc ^ 8'($urandom_range(1, 255)), ROW_PREDICT);
                    end else begin
                        send_rx_byte(fr_crc, ROW_PREDICT);
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // result side stalls in segments of varying density, plus one long hold
    initial begin
        int seg;
        int pct;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            seg = $urandom_range(4, 60);
            case ($urandom_range(0, 2))
                0: pct = 100;
                1: pct = 70;
                default: pct = 25;
            endcase
            while (seg > 0 && !hold_request) begin
                i_ready <= ($urandom_range(1, 100) <= pct);
                @(posedge i_clk);
                seg--;
            end
        end
    end

    always @(posedge i_clk) begin
        rx_result_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(o_result_kind));
                check_field("text_byte", 64'(want.text), 64'(o_text_byte));
                check_field("message_id", 64'(want.id), 64'(o_message_id));
                check_field("payload_length", 64'(want.len), 64'(o_payload_length));
                check_field("payload_data", want.data, o_payload_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] settings [4];
        settings = '{8'h00, 8'hFF, 8'($urandom), START_BYTE_RST};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_start = START_BYTE_RST;
        tracker_idle();

        foreach (directed_rows[k]) begin
            case (directed_rows[k].how)
                ROW_CRC_GOOD: send_rx_byte(fr_crc, ROW_PREDICT);
                ROW_CRC_BAD:  send_rx_byte(fr_crc ^ 8'h01, ROW_QUIET);
                default:      send_rx_byte(directed_rows[k].value, directed_rows[k].how);
            endcase
        end
        finish_frame_and_drain();

        foreach (settings[p]) begin
            write_start_byte(settings[p]);
            if (p == 1) begin
                hold_request = 1'b1;
            end
            random_traffic(items_sent + PHASE_ITEMS);
            finish_frame_and_drain();
        end

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
